### rtl/core/gregorian_date_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// gregorian date arithmetic unit: assertion macros
// shared property forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITH_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ARITH_UNIT_DEFINES_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gregorian_date_arith_unit: same-cycle check failed");

// next-cycle implication
`define GDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gregorian_date_arith_unit: next-cycle check failed");

`endif

### rtl/core/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// types, constants and calendar helpers shared by the date arithmetic unit
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int MAX_YEAR_DEF = 9999;

    localparam int DayW     = 5;
    localparam int MonthW   = 4;
    localparam int YearW    = 14;
    localparam int OffsetW  = 20;
    localparam int DiffW    = 22;
    localparam int StatusW  = 2;
    localparam int OrderW   = 2;
    localparam int DaysW    = 24;
    localparam int CurYearW = 15;
    localparam int LimYearW = 17;

    localparam int BASE_YEAR  = 1900;
    localparam int EPOCH_YEAR = 1600;

    localparam int YearFieldMax = 2**YearW - 1;
    localparam int DiffMax      = 2**DiffW - 1;

    localparam logic [DaysW-1:0] DAYS_400      = DaysW'(146097);
    localparam logic [DaysW-1:0] DAYS_100_LEAP = DaysW'(36525);
    localparam logic [DaysW-1:0] DAYS_100      = DaysW'(36524);
    localparam logic [DaysW-1:0] DAYS_4_LEAP   = DaysW'(1461);
    localparam logic [DaysW-1:0] DAYS_4        = DaysW'(1460);
    localparam logic [DaysW-1:0] DAYS_1_LEAP   = DaysW'(366);
    localparam logic [DaysW-1:0] DAYS_1        = DaysW'(365);

    localparam logic [StatusW-1:0] STAT_OK         = 2'd0;
    localparam logic [StatusW-1:0] STAT_BAD_FIRST  = 2'd1;
    localparam logic [StatusW-1:0] STAT_BAD_SECOND = 2'd2;
    localparam logic [StatusW-1:0] STAT_OVERFLOW   = 2'd3;

    localparam logic [OrderW-1:0] ORD_EQUAL   = 2'd0;
    localparam logic [OrderW-1:0] ORD_EARLIER = 2'd1;
    localparam logic [OrderW-1:0] ORD_LATER   = 2'd2;

    typedef enum logic [2:0] {
        PH_Y400,
        PH_Y100,
        PH_Y4,
        PH_Y1,
        PH_MON
    } t_phase;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_STEP,
        DP_FIN,
        DP_ERR,
        DP_REND,
        DP_DIFF,
        DP_PUSH
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VAL,
        ST_F400,
        ST_F100,
        ST_F4,
        ST_F1,
        ST_FMON,
        ST_FEND,
        ST_R400,
        ST_R100,
        ST_R4,
        ST_R1,
        ST_RMON,
        ST_REND,
        ST_DIFF,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        t_phase phase;
        logic   rev;
    } t_dp_cmd;

    typedef struct packed {
        logic range_ok;
        logic step_ok;
        logic day_ok;
        logic kind;
        logic sel;
        logic out_free;
    } t_dp_stat;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/gda_datapath.sv
// ----------------------------------------------------------------------------
// gda_datapath
// operand and result registers, calendar stepping unit and output register
// ----------------------------------------------------------------------------
module gda_datapath
    import gda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_kind,
    input  logic [DayW-1:0]     i_first_day,
    input  logic [MonthW-1:0]   i_first_month,
    input  logic [YearW-1:0]    i_first_year,
    input  logic [DayW-1:0]     i_second_day,
    input  logic [MonthW-1:0]   i_second_month,
    input  logic [YearW-1:0]    i_second_year,
    input  logic [OffsetW-1:0]  i_day_offset,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [StatusW-1:0]  o_status,
    output logic [DayW-1:0]     o_result_day,
    output logic [MonthW-1:0]   o_result_month,
    output logic [YearW-1:0]    o_result_year,
    output logic [DiffW-1:0]    o_day_difference,
    output logic [OrderW-1:0]   o_order
);

    localparam logic [LimYearW-1:0] MaxYearW = LimYearW'(MAX_YEAR);

    // captured operands
    logic                r_kind;
    logic [DayW-1:0]     r_d1;
    logic [MonthW-1:0]   r_m1;
    logic [YearW-1:0]    r_y1;
    logic [DayW-1:0]     r_d2;
    logic [MonthW-1:0]   r_m2;
    logic [YearW-1:0]    r_y2;
    logic [OffsetW-1:0]  r_off;
    logic                r_sel;

    // stepping state
    logic [CurYearW-1:0] r_year;
    logic [DaysW-1:0]    r_days;
    logic [DaysW-1:0]    r_n1;
    logic [MonthW-1:0]   r_month;
    logic [1:0]          r_c100;
    logic [4:0]          r_c4;
    logic [1:0]          r_c1;

    // pending result
    logic [StatusW-1:0]  r_res_status;
    logic [DayW-1:0]     r_res_day;
    logic [MonthW-1:0]   r_res_month;
    logic [YearW-1:0]    r_res_year;
    logic [DiffW-1:0]    r_res_diff;
    logic [OrderW-1:0]   r_res_order;

    // output register
    logic                r_out_valid;
    logic [StatusW-1:0]  r_out_status;
    logic [DayW-1:0]     r_out_day;
    logic [MonthW-1:0]   r_out_month;
    logic [YearW-1:0]    r_out_year;
    logic [DiffW-1:0]    r_out_diff;
    logic [OrderW-1:0]   r_out_order;

    logic [DayW-1:0]     t_day;
    logic [MonthW-1:0]   t_month;
    logic [YearW-1:0]    t_year;
    logic                leap;
    logic [DayW-1:0]     cur_mlen;
    logic [DaysW-1:0]    step_len;
    logic [8:0]          year_inc;
    logic                lim_ok;
    logic [CurYearW:0]   year_next;
    logic                step_ok;
    logic [DaysW-1:0]    dn;
    logic                ovf;
    logic [DaysW-1:0]    diff_abs;
    logic [OrderW-1:0]   diff_ord;
    logic [DiffW-1:0]    diff_sat;
    logic                out_free;

    assign t_day   = r_sel ? r_d2 : r_d1;
    assign t_month = r_sel ? r_m2 : r_m1;
    assign t_year  = r_sel ? r_y2 : r_y1;

    // leap year from the position inside the 400-year cycle
    assign leap     = (r_c1 == 2'd0) && !((r_c4 == 5'd0) && (r_c100 != 2'd0));
    assign cur_mlen = month_len(r_month, leap);

    always_comb begin
        step_len = DAYS_400;
        year_inc = 9'd400;
        lim_ok   = 1'b1;
        unique case (i_cmd.phase)
            PH_Y400: begin
                step_len = DAYS_400;
                year_inc = 9'd400;
                lim_ok   = 1'b1;
            end
            PH_Y100: begin
                step_len = (r_c100 == 2'd0) ? DAYS_100_LEAP : DAYS_100;
                year_inc = 9'd100;
                lim_ok   = (r_c100 != 2'd3);
            end
            PH_Y4: begin
                step_len = ((r_c4 == 5'd0) && (r_c100 != 2'd0)) ? DAYS_4 : DAYS_4_LEAP;
                year_inc = 9'd4;
                lim_ok   = (r_c4 != 5'd24);
            end
            PH_Y1: begin
                step_len = leap ? DAYS_1_LEAP : DAYS_1;
                year_inc = 9'd1;
                lim_ok   = (r_c1 != 2'd3);
            end
            PH_MON: begin
                step_len = DaysW'(cur_mlen);
                year_inc = 9'd0;
                lim_ok   = (r_month != 4'd12);
            end
            default: begin
                step_len = DAYS_400;
                year_inc = 9'd0;
                lim_ok   = 1'b0;
            end
        endcase
    end

    assign year_next = {1'b0, r_year} + (CurYearW + 1)'(year_inc);

    always_comb begin
        if (i_cmd.rev) begin
            step_ok = lim_ok && (r_days >= step_len);
        end else if (i_cmd.phase == PH_MON) begin
            step_ok = (r_month < t_month);
        end else begin
            step_ok = (year_next <= (CurYearW + 1)'(t_year));
        end
    end

    assign dn  = r_days + DaysW'(t_day) - DaysW'(1);
    assign ovf = (LimYearW'(r_year) > MaxYearW) || (r_year > CurYearW'(YearFieldMax));

    always_comb begin
        if (r_n1 < r_days) begin
            diff_abs = r_days - r_n1;
            diff_ord = ORD_EARLIER;
        end else if (r_n1 > r_days) begin
            diff_abs = r_n1 - r_days;
            diff_ord = ORD_LATER;
        end else begin
            diff_abs = '0;
            diff_ord = ORD_EQUAL;
        end
    end

    assign diff_sat = (diff_abs > DaysW'(DiffMax)) ? DiffW'(DiffMax) : diff_abs[DiffW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.range_ok = (t_year >= YearW'(BASE_YEAR))
                          && (LimYearW'(t_year) <= MaxYearW)
                          && (t_month >= 4'd1) && (t_month <= 4'd12);
    assign o_stat.step_ok  = step_ok;
    assign o_stat.day_ok   = (t_day != '0) && (t_day <= cur_mlen);
    assign o_stat.kind     = r_kind;
    assign o_stat.sel      = r_sel;
    assign o_stat.out_free = out_free;

    // operands and stepping
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_kind <= i_kind;
                r_d1   <= i_first_day;
                r_m1   <= i_first_month;
                r_y1   <= i_first_year;
                r_d2   <= i_second_day;
                r_m2   <= i_second_month;
                r_y2   <= i_second_year;
                r_off  <= i_day_offset;
                r_sel  <= 1'b0;
            end
            DP_INIT: begin
                r_year  <= CurYearW'(EPOCH_YEAR);
                r_days  <= '0;
                r_month <= 4'd1;
                r_c100  <= '0;
                r_c4    <= '0;
                r_c1    <= '0;
            end
            DP_STEP: begin
                r_days <= i_cmd.rev ? (r_days - step_len) : (r_days + step_len);
                r_year <= year_next[CurYearW-1:0];
                unique case (i_cmd.phase)
                    PH_Y100: r_c100  <= r_c100 + 2'd1;
                    PH_Y4:   r_c4    <= r_c4 + 5'd1;
                    PH_Y1:   r_c1    <= r_c1 + 2'd1;
                    PH_MON:  r_month <= r_month + 4'd1;
                    default: ;
                endcase
            end
            DP_FIN: begin
                // first date: keep its day number, preload sum for the add
                if (!r_sel) begin
                    r_n1   <= dn;
                    r_days <= dn + DaysW'(r_off);
                end else begin
                    r_days <= dn;
                end
                r_sel   <= 1'b1;
                r_year  <= CurYearW'(EPOCH_YEAR);
                r_month <= 4'd1;
                r_c100  <= '0;
                r_c4    <= '0;
                r_c1    <= '0;
            end
            default: ;
        endcase
    end

    // pending result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_res_status <= STAT_OK;
                r_res_day    <= '0;
                r_res_month  <= '0;
                r_res_year   <= '0;
                r_res_diff   <= '0;
                r_res_order  <= ORD_EQUAL;
            end
            DP_ERR: begin
                r_res_status <= r_sel ? STAT_BAD_SECOND : STAT_BAD_FIRST;
            end
            DP_REND: begin
                if (ovf) begin
                    r_res_status <= STAT_OVERFLOW;
                end else begin
                    r_res_day   <= r_days[DayW-1:0] + DayW'(1);
                    r_res_month <= r_month;
                    r_res_year  <= r_year[YearW-1:0];
                end
            end
            DP_DIFF: begin
                r_res_diff  <= diff_sat;
                r_res_order <= diff_ord;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_PUSH) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_PUSH) begin
            r_out_status <= r_res_status;
            r_out_day    <= r_res_day;
            r_out_month  <= r_res_month;
            r_out_year   <= r_res_year;
            r_out_diff   <= r_res_diff;
            r_out_order  <= r_res_order;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_day     = r_out_day;
    assign o_result_month   = r_out_month;
    assign o_result_year    = r_out_year;
    assign o_day_difference = r_out_diff;
    assign o_order          = r_out_order;

endmodule

### rtl/core/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// sequencer that walks the calendar phases and commands the datapath
// ----------------------------------------------------------------------------
module gda_ctrl
    import gda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_VAL;
            ST_VAL:  n_state = i_stat.range_ok ? ST_F400 : ST_DONE;
            ST_F400: if (!i_stat.step_ok) n_state = ST_F100;
            ST_F100: if (!i_stat.step_ok) n_state = ST_F4;
            ST_F4:   if (!i_stat.step_ok) n_state = ST_F1;
            ST_F1:   if (!i_stat.step_ok) n_state = ST_FMON;
            ST_FMON: if (!i_stat.step_ok) n_state = ST_FEND;
            ST_FEND: begin
                priority if (!i_stat.day_ok) n_state = ST_DONE;
                else if (!i_stat.kind)       n_state = ST_R400;
                else if (!i_stat.sel)        n_state = ST_VAL;
                else                         n_state = ST_DIFF;
            end
            ST_R400: if (!i_stat.step_ok) n_state = ST_R100;
            ST_R100: if (!i_stat.step_ok) n_state = ST_R4;
            ST_R4:   if (!i_stat.step_ok) n_state = ST_R1;
            ST_R1:   if (!i_stat.step_ok) n_state = ST_RMON;
            ST_RMON: if (!i_stat.step_ok) n_state = ST_REND;
            ST_REND: n_state = ST_DONE;
            ST_DIFF: n_state = ST_DONE;
            ST_DONE: if (i_stat.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op    = DP_NOP;
        o_cmd.phase = PH_Y400;
        o_cmd.rev   = 1'b0;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) o_cmd.op = DP_LOAD;
            ST_VAL:  o_cmd.op = i_stat.range_ok ? DP_INIT : DP_ERR;
            ST_F400: begin
                o_cmd.phase = PH_Y400;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_F100: begin
                o_cmd.phase = PH_Y100;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_F4: begin
                o_cmd.phase = PH_Y4;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_F1: begin
                o_cmd.phase = PH_Y1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_FMON: begin
                o_cmd.phase = PH_MON;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_FEND: o_cmd.op = i_stat.day_ok ? DP_FIN : DP_ERR;
            ST_R400: begin
                o_cmd.phase = PH_Y400;
                o_cmd.rev   = 1'b1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_R100: begin
                o_cmd.phase = PH_Y100;
                o_cmd.rev   = 1'b1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_R4: begin
                o_cmd.phase = PH_Y4;
                o_cmd.rev   = 1'b1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_R1: begin
                o_cmd.phase = PH_Y1;
                o_cmd.rev   = 1'b1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_RMON: begin
                o_cmd.phase = PH_MON;
                o_cmd.rev   = 1'b1;
                if (i_stat.step_ok) o_cmd.op = DP_STEP;
            end
            ST_REND: o_cmd.op = DP_REND;
            ST_DIFF: o_cmd.op = DP_DIFF;
            ST_DONE: if (i_stat.out_free) o_cmd.op = DP_PUSH;
            default: o_cmd.op = DP_NOP;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### rtl/core/gregorian_date_arith_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_arith_unit
// Gregorian date add and difference unit. Kind 0 adds a day offset to the
// first date, kind 1 returns the absolute day count between the two dates and
// their order; an invalid date (year below 1900 or above MAX_YEAR, bad month
// or day) or a sum past MAX_YEAR gives an error status with zero results. One
// item is in work at a time: a date is turned into a day count from 1 Jan 1600
// by stepping whole 400-year cycles, then centuries, 4-year blocks, years and
// months, and a sum is turned back the same way, one step per cycle. The time
// an item takes is set by the number of year and month steps for each date,
// plus any wait on output stall before its result can be loaded; a finished
// result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "gregorian_date_arith_unit_defines.svh"

module gregorian_date_arith_unit
    import gda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [DayW-1:0]     i_first_day,
    input  logic [MonthW-1:0]   i_first_month,
    input  logic [YearW-1:0]    i_first_year,
    input  logic [DayW-1:0]     i_second_day,
    input  logic [MonthW-1:0]   i_second_month,
    input  logic [YearW-1:0]    i_second_year,
    input  logic [OffsetW-1:0]  i_day_offset,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [StatusW-1:0]  o_status,
    output logic [DayW-1:0]     o_result_day,
    output logic [MonthW-1:0]   o_result_month,
    output logic [YearW-1:0]    o_result_year,
    output logic [DiffW-1:0]    o_day_difference,
    output logic [OrderW-1:0]   o_order
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     res_fields_zero;

    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    gda_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_kind           (i_kind),
        .i_first_day      (i_first_day),
        .i_first_month    (i_first_month),
        .i_first_year     (i_first_year),
        .i_second_day     (i_second_day),
        .i_second_month   (i_second_month),
        .i_second_year    (i_second_year),
        .i_day_offset     (i_day_offset),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_result_day     (o_result_day),
        .o_result_month   (o_result_month),
        .o_result_year    (o_result_year),
        .o_day_difference (o_day_difference),
        .o_order          (o_order)
    );

    assign res_fields_zero = (o_result_day == '0) && (o_result_month == '0)
                          && (o_result_year == '0) && (o_day_difference == '0)
                          && (o_order == ORD_EQUAL);

    `GDA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `GDA_ASSERT_IMP(a_push_slot_free, dp_cmd.op == DP_PUSH, !o_out_valid || !i_out_stall)
    `GDA_ASSERT_IMP(a_error_zero_fields, o_out_valid && (o_status != STAT_OK), res_fields_zero)
    `GDA_ASSERT_IMP(a_equal_zero_diff, o_out_valid && (o_order == ORD_EQUAL), o_day_difference == '0)

endmodule
